// File: hw/rtl/positional_insert_delete_list_macros.svh
// Assertion helpers for the list RTL.
// Each expects a clock named clk and a reset named arst_n in scope.
`ifndef POSITIONAL_INSERT_DELETE_LIST_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_LIST_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define PIDL_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pidl check failed");

// Consequent holds in the cycle after the antecedent.
`define PIDL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pidl check failed");

`endif

// File: hw/rtl/pidl_pkg.sv
`default_nettype none
package pidl_pkg;
	localparam int CAPACITY = 32;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 6;
	localparam int LEN_W    = 6;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_GET    = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		SHIFT_HOLD = 2'd0,
		SHIFT_INS  = 2'd1,
		SHIFT_DEL  = 2'd2
	} shift_op_t;

	// Broadcast to every cell of the row
	typedef struct packed {
		shift_op_t          op;
		logic [POS_W-1:0]   idx;
		logic [DATA_W-1:0]  value;
	} cell_ctl_t;
endpackage
`default_nettype wire

// File: hw/rtl/pidl_if.sv
`default_nettype none
interface pidl_cmd_if import pidl_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [1:0]               command;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output command, output position, output value,
		input ready);
	modport sink (input valid, input command, input position, input value,
		output ready);
endinterface

interface pidl_rsp_if import pidl_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic                     status;
	logic signed [DATA_W-1:0] read_value;
	logic [LEN_W-1:0]         list_length;
	logic                     is_empty;

	modport source (output valid, output status, output read_value,
		output list_length, output is_empty, input ready);
	modport sink (input valid, input status, input read_value,
		input list_length, input is_empty, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/pidl_cell.sv
`default_nettype none
module pidl_cell import pidl_pkg::*; (
	input  wire logic              clk,
	input  wire logic [POS_W-1:0]  slot_idx,
	input  wire cell_ctl_t         ctl,
	input  wire logic [DATA_W-1:0] left,
	input  wire logic [DATA_W-1:0] right,
	output      logic [DATA_W-1:0] slot,
	output      logic [DATA_W-1:0] tap
);
	logic [DATA_W-1:0] slot_q;
	logic [DATA_W-1:0] slot_d;

	always_comb begin
		slot_d = slot_q;
		unique case (ctl.op)
			SHIFT_INS: begin
				// take from below the insertion point, drop the new beat in at it
				if (slot_idx > ctl.idx) begin
					slot_d = left;
				end else if (slot_idx == ctl.idx) begin
					slot_d = ctl.value;
				end
			end
			SHIFT_DEL: begin
				if (slot_idx >= ctl.idx) begin
					slot_d = right;
				end
			end
			default: slot_d = slot_q;
		endcase
	end

	always_ff @(posedge clk) begin
		slot_q <= slot_d;
	end

	assign slot = slot_q;
	assign tap  = (slot_idx == ctl.idx) ? slot_q : '0;
endmodule
`default_nettype wire

// File: hw/rtl/positional_insert_delete_list.sv
// Bounded positional list of up to 32 signed 32-bit entries.
// Command channel (cmd): command, 1-based position and value. Insert puts
// the value before the position and moves later entries up; delete returns
// the entry at the position and closes the gap; get reads it; clear empties
// the list. A bad position or a full list gives status 1 and no change.
// Response channel (rsp): one beat per command with status, read value
// (zero unless delete or get succeeded), length after the command and an
// empty flag.
// Latency: the response is valid the cycle after the command is accepted.
// Throughput: one command per cycle. Every slot sits in a cell of a row
// that shifts up or down all at once, and the length count is the
// only dependency from one command to the next.
// Stall: the response register holds its beat until taken; a new command
// is accepted in the same cycle as the held beat leaves, otherwise not.
// Reset: the length count and the response valid clear at once; slot
// contents are left undefined and are never read before being written.
`default_nettype none
`include "positional_insert_delete_list_macros.svh"
module positional_insert_delete_list import pidl_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pidl_cmd_if.sink   cmd,
	pidl_rsp_if.source rsp
);
	logic [LEN_W-1:0]  count_q;
	logic [LEN_W-1:0]  count_d;
	logic              rsp_valid_q;
	logic              rsp_status_q;
	logic [DATA_W-1:0] rsp_rdata_q;
	logic [LEN_W-1:0]  rsp_len_q;
	logic              rsp_empty_q;

	logic              accept;
	cmd_t              cmd_code;
	logic              err;
	logic              rd_en;
	shift_op_t         op;
	cell_ctl_t         ctl;
	logic [DATA_W-1:0] tap_or;
	logic [DATA_W-1:0] rd_value;
	logic              pos_ok_ins;
	logic              pos_ok_rd;

	logic [DATA_W-1:0] slots [CAPACITY];
	logic [DATA_W-1:0] taps  [CAPACITY];

	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign accept    = cmd.valid && cmd.ready;
	assign cmd_code  = cmd_t'(cmd.command);

	assign pos_ok_ins = (cmd.position != '0) && (cmd.position <= count_q + LEN_W'(1))
		&& (count_q < LEN_W'(CAPACITY));
	assign pos_ok_rd  = (cmd.position != '0) && (cmd.position <= count_q);

	always_comb begin
		err     = 1'b0;
		rd_en   = 1'b0;
		op      = SHIFT_HOLD;
		count_d = count_q;
		unique case (cmd_code)
			CMD_INSERT: begin
				err = !pos_ok_ins;
				if (pos_ok_ins) begin
					op      = SHIFT_INS;
					count_d = count_q + LEN_W'(1);
				end
			end
			CMD_DELETE: begin
				err   = !pos_ok_rd;
				rd_en = pos_ok_rd;
				if (pos_ok_rd) begin
					op      = SHIFT_DEL;
					count_d = count_q - LEN_W'(1);
				end
			end
			CMD_GET: begin
				err   = !pos_ok_rd;
				rd_en = pos_ok_rd;
			end
			CMD_CLEAR: begin
				count_d = '0;
			end
		endcase
	end

	always_comb begin
		ctl.op    = accept ? op : SHIFT_HOLD;
		ctl.idx   = cmd.position - POS_W'(1);
		ctl.value = cmd.value;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_nb;
		logic [DATA_W-1:0] right_nb;

		if (i == 0) begin : g_first
			assign left_nb = cmd.value;
		end else begin : g_inner_l
			assign left_nb = slots[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_nb = slots[i];
		end else begin : g_inner_r
			assign right_nb = slots[i+1];
		end

		pidl_cell u_cell (
			.clk      (clk),
			.slot_idx (POS_W'(i)),
			.ctl      (ctl),
			.left     (left_nb),
			.right    (right_nb),
			.slot     (slots[i]),
			.tap      (taps[i])
		);
	end

	// at most one tap is non-zero
	always_comb begin
		tap_or = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			tap_or = tap_or | taps[k];
		end
	end

	assign rd_value = rd_en ? tap_or : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_status_q <= err;
			rsp_rdata_q  <= rd_value;
			rsp_len_q    <= count_d;
			rsp_empty_q  <= (count_d == '0);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.read_value  = rsp_rdata_q;
	assign rsp.list_length = rsp_len_q;
	assign rsp.is_empty    = rsp_empty_q;

	`PIDL_ASSERT_NOW(a_count_bound, 1'b1, count_q <= LEN_W'(CAPACITY))
	`PIDL_ASSERT_NEXT(a_err_keeps_count, accept && err, count_q == $past(count_q))
	`PIDL_ASSERT_NEXT(a_ins_grows, accept && !err && cmd_code == CMD_INSERT, count_q == $past(count_q) + LEN_W'(1))
	`PIDL_ASSERT_NOW(a_empty_flag, rsp_valid_q, rsp_empty_q == (rsp_len_q == '0))
	`PIDL_ASSERT_NOW(a_stall_blocks, rsp_valid_q && !rsp.ready, !cmd.ready)
endmodule
`default_nettype wire

// File: dv/positional_insert_delete_list_tb.sv
`default_nettype none
module positional_insert_delete_list_tb import pidl_pkg::*;;

	typedef struct packed {
		logic               status;
		logic [DATA_W-1:0]  read_value;
		logic [LEN_W-1:0]   list_length;
		logic               is_empty;
	} list_beat_t;

	logic clk;
	logic arst_n;

	pidl_cmd_if cmd_ch ();
	pidl_rsp_if rsp_ch ();

	positional_insert_delete_list dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// Mirror of the list contents and length
	logic [DATA_W-1:0] list_slots [CAPACITY];
	int                list_len;
	list_beat_t        pending_beats[$];

	int send_idle_pct;
	int rsp_stall_pct;
	int rsp_hold_left;

	int fail_count;
	int cmds_sent;
	int cmds_rejected;
	int full_refusals;
	int beats_checked;
	int peak_len;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("timeout at %0t with %0d beats outstanding", $time, pending_beats.size());
		$display("** positional_insert_delete_list: FAILED **");
		$finish;
	end

	// Work out the beat one command gives and update the mirror
	function automatic list_beat_t list_apply(cmd_t op, logic [POS_W-1:0] pos,
			logic [DATA_W-1:0] val);
		list_beat_t beat;
		int         p;
		beat = '0;
		p = int'(pos);
		case (op)
		CMD_INSERT: begin
			if (list_len >= CAPACITY || p < 1 || p > list_len + 1) begin
				beat.status = 1'b1;
				if (list_len >= CAPACITY)
					full_refusals++;
			end else begin
				for (int i = list_len; i > p - 1; i--)
					list_slots[i] = list_slots[i-1];
				list_slots[p-1] = val;
				list_len++;
			end
		end
		CMD_DELETE: begin
			if (p < 1 || p > list_len) begin
				beat.status = 1'b1;
			end else begin
				beat.read_value = list_slots[p-1];
				for (int i = p - 1; i < list_len - 1; i++)
					list_slots[i] = list_slots[i+1];
				list_len--;
			end
		end
		CMD_GET: begin
			if (p < 1 || p > list_len)
				beat.status = 1'b1;
			else
				beat.read_value = list_slots[p-1];
		end
		default: list_len = 0;
		endcase
		if (beat.status)
			cmds_rejected++;
		if (list_len > peak_len)
			peak_len = list_len;
		beat.list_length = list_len[LEN_W-1:0];
		beat.is_empty = (list_len == 0);
		return beat;
	endfunction

	// Offer one command; returns at the edge where it is taken
	task automatic send_command(cmd_t op, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid    <= 1'b0;
			cmd_ch.command  <= 2'($urandom_range(3));
			cmd_ch.position <= POS_W'($urandom_range(63));
			cmd_ch.value    <= $urandom;
			@(posedge clk);
		end
		cmd_ch.valid    <= 1'b1;
		cmd_ch.command  <= op;
		cmd_ch.position <= pos;
		cmd_ch.value    <= val;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		pending_beats.push_back(list_apply(op, pos, val));
		cmds_sent++;
	endtask

	task automatic send_random_command(int ins_pct);
		cmd_t              op;
		int                roll;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] val;
		roll = $urandom_range(99);
		if (roll < ins_pct)
			op = CMD_INSERT;
		else if (roll < ins_pct + 25)
			op = CMD_DELETE;
		else if (roll < 98)
			op = CMD_GET;
		else
			op = CMD_CLEAR;
		// Mostly legal positions, some noise over the whole field
		if ($urandom_range(99) < 15)
			pos = POS_W'($urandom_range(63));
		else if (op == CMD_INSERT)
			pos = POS_W'($urandom_range(list_len + 1, 1));
		else if (list_len > 0)
			pos = POS_W'($urandom_range(list_len, 1));
		else
			pos = POS_W'($urandom_range(63));
		case ($urandom_range(19))
		0: val = 32'h8000_0000;
		1: val = 32'h7FFF_FFFF;
		2: val = '0;
		3: val = '1;
		default: val = $urandom;
		endcase
		send_command(op, pos, val);
	endtask

	// Drop valid and hold until every beat has come back
	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		send_command(CMD_GET, 1, $urandom);
		send_command(CMD_DELETE, 1, $urandom);
		send_command(CMD_INSERT, 0, 32'h1234_5678);
		send_command(CMD_INSERT, 2, 32'h1234_5678);
		send_command(CMD_INSERT, 1, 32'h7FFF_FFFF);
		send_command(CMD_INSERT, 1, 32'h8000_0000);
		send_command(CMD_INSERT, 3, 32'hFFFF_FFFF);
		send_command(CMD_INSERT, 2, 32'h0000_0000);
		send_command(CMD_INSERT, 6, 32'hDEAD_BEEF);
		send_command(CMD_INSERT, 63, 32'hDEAD_BEEF);
		send_command(CMD_GET, 1, $urandom);
		send_command(CMD_GET, 4, $urandom);
		send_command(CMD_GET, 5, $urandom);
		send_command(CMD_GET, 0, $urandom);
		send_command(CMD_GET, 63, $urandom);
		send_command(CMD_DELETE, 0, $urandom);
		send_command(CMD_DELETE, 5, $urandom);
		send_command(CMD_DELETE, 2, $urandom);
		send_command(CMD_DELETE, 3, $urandom);
		send_command(CMD_DELETE, 1, $urandom);
		send_command(CMD_CLEAR, POS_W'($urandom_range(63)), $urandom);
		send_command(CMD_CLEAR, POS_W'($urandom_range(63)), $urandom);
		send_command(CMD_GET, 1, $urandom);
		send_command(CMD_INSERT, 1, 32'h5A5A_5A5A);
		send_command(CMD_DELETE, 1, $urandom);
		wait_drained();
	endtask

	task automatic test_full_list();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		while (list_len < CAPACITY)
			send_command(CMD_INSERT, POS_W'($urandom_range(list_len + 1, 1)), $urandom);
		send_command(CMD_INSERT, 1, $urandom);
		send_command(CMD_INSERT, POS_W'(CAPACITY + 1), $urandom);
		send_command(CMD_GET, POS_W'(CAPACITY), $urandom);
		send_command(CMD_GET, POS_W'(CAPACITY + 1), $urandom);
		send_command(CMD_DELETE, POS_W'(CAPACITY), $urandom);
		send_command(CMD_INSERT, POS_W'(CAPACITY), $urandom);
		send_command(CMD_DELETE, 1, $urandom);
		send_command(CMD_INSERT, POS_W'(CAPACITY), $urandom);
		send_command(CMD_GET, 1, $urandom);
		send_command(CMD_CLEAR, POS_W'($urandom_range(63)), $urandom);
		wait_drained();
	endtask

	task automatic test_idle_phase(int send_pct, int stall_pct, int n_cmds, int ins_pct);
		send_idle_pct = send_pct;
		rsp_stall_pct = stall_pct;
		repeat (n_cmds)
			send_random_command(ins_pct);
		wait_drained();
	endtask

	// Hold the response side off so the block stalls its command side
	task automatic test_backpressure();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		rsp_hold_left = 60;
		repeat (20)
			send_random_command(45);
		wait_drained();
	endtask

	task automatic test_drain_pause();
		send_idle_pct = 23;
		rsp_stall_pct = 23;
		repeat (15)
			send_random_command(45);
		wait_drained();
		repeat (20)
			@(posedge clk);
		repeat (15)
			send_random_command(45);
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (rsp_hold_left > 0) begin
			rsp_ch.ready <= 1'b0;
			rsp_hold_left = rsp_hold_left - 1;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	task automatic report_mismatch(string field, logic [DATA_W-1:0] exp_v,
			logic [DATA_W-1:0] act_v);
		$display("%0t: %s mismatch, expected %0h actual %0h", $time, field, exp_v, act_v);
		fail_count++;
	endtask

	always @(posedge clk) begin
		list_beat_t exp_beat;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected beat, expected none actual status %0b value %0h",
					$time, rsp_ch.status, rsp_ch.read_value);
				fail_count++;
			end else begin
				exp_beat = pending_beats.pop_front();
				beats_checked++;
				if (rsp_ch.status !== exp_beat.status)
					report_mismatch("status", DATA_W'(exp_beat.status),
						DATA_W'(rsp_ch.status));
				if (rsp_ch.read_value !== exp_beat.read_value)
					report_mismatch("read_value", exp_beat.read_value, rsp_ch.read_value);
				if (rsp_ch.list_length !== exp_beat.list_length)
					report_mismatch("list_length", DATA_W'(exp_beat.list_length),
						DATA_W'(rsp_ch.list_length));
				if (rsp_ch.is_empty !== exp_beat.is_empty)
					report_mismatch("is_empty", DATA_W'(exp_beat.is_empty),
						DATA_W'(rsp_ch.is_empty));
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		cmd_ch.valid    = 1'b0;
		cmd_ch.command  = CMD_GET;
		cmd_ch.position = '0;
		cmd_ch.value    = '0;
		rsp_ch.ready    = 1'b0;
		list_len        = 0;
		send_idle_pct   = 0;
		rsp_stall_pct   = 0;
		rsp_hold_left   = 0;
		fail_count      = 0;
		cmds_sent       = 0;
		cmds_rejected   = 0;
		full_refusals   = 0;
		beats_checked   = 0;
		peak_len        = 0;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_list();
		test_idle_phase(0, 0, 150, 50);
		test_idle_phase(47, 0, 150, 30);
		test_idle_phase(0, 47, 150, 50);
		test_idle_phase(23, 23, 150, 35);
		test_backpressure();
		test_drain_pause();

		repeat (5)
			@(posedge clk);
		$display("Sent %0d commands, %0d rejected (%0d on a full list), peak length %0d",
			cmds_sent, cmds_rejected, full_refusals, peak_len);
		$display("Checked %0d response beats across idle, stall and hold-off phases",
			beats_checked);
		if (fail_count == 0)
			$display("** positional_insert_delete_list: PASSED **");
		else
			$display("** positional_insert_delete_list: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire

// File: sim.f
+incdir+hw/rtl
hw/rtl/pidl_pkg.sv
hw/rtl/pidl_if.sv
hw/rtl/pidl_cell.sv
hw/rtl/positional_insert_delete_list.sv
dv/positional_insert_delete_list_tb.sv
